>>> design/hrhf_pkg.sv
package hrhf_pkg;

   localparam int LEN_BITS = 40;
   localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

   localparam logic CSR_MAX_BODY_SIZE = 1'b0;
   localparam logic CSR_BODY_METHOD_MASK = 1'b1;

   localparam logic [LEN_BITS-1:0] MAX_BODY_RESET = LEN_BITS'(1048576);
   localparam logic [6:0] BODY_MASK_RESET = 7'd30;

   localparam logic [1:0] ST_CONTINUE = 2'd0;
   localparam logic [1:0] ST_BAD = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;
   localparam logic [1:0] ST_TOO_LARGE = 2'd3;

   localparam logic [2:0] CLS_METHOD = 3'd0;
   localparam logic [2:0] CLS_URI = 3'd1;
   localparam logic [2:0] CLS_VERSION = 3'd2;
   localparam logic [2:0] CLS_DELIM = 3'd3;
   localparam logic [2:0] CLS_KEY = 3'd4;
   localparam logic [2:0] CLS_VALUE = 3'd5;
   localparam logic [2:0] CLS_BODY = 3'd6;

   localparam logic [1:0] VER_UNKNOWN = 2'd0;
   localparam logic [1:0] VER_10 = 2'd1;
   localparam logic [1:0] VER_11 = 2'd2;

   localparam logic [7:0] METH_NAME [7][7] = '{
      '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00},
      '{"P", "A", "T", "C", "H", 8'h00, 8'h00},
      '{"D", "E", "L", "E", "T", "E", 8'h00},
      '{"O", "P", "T", "I", "O", "N", "S"},
      '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00}
   };
   localparam logic [3:0] METH_LEN [7] = '{4'd3, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd4};

   localparam logic [7:0] VER_TEXT [8] = '{"H", "T", "T", "P", "/", "1", ".", 8'h00};

   localparam logic [4:0] CLEN_LEN = 5'd14;
   localparam logic [4:0] CONN_LEN = 5'd10;
   localparam logic [4:0] KA_LEN = 5'd10;
   localparam logic [4:0] MATCH_SAT = 5'd31;

   localparam logic [7:0] KEY_CLEN [16] = '{"c", "o", "n", "t", "e", "n", "t", "-",
      "l", "e", "n", "g", "t", "h", 8'h00, 8'h00};
   localparam logic [7:0] KEY_CONN [16] = '{"c", "o", "n", "n", "e", "c", "t", "i",
      "o", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
   localparam logic [7:0] VAL_KA [16] = '{"k", "e", "e", "p", "-", "a", "l", "i",
      "v", "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};

   typedef enum logic [3:0] {
      S_METHOD, S_URI, S_VERSION, S_LF1, S_HKEY, S_HSPACE,
      S_HVALUE, S_LF2, S_LF3, S_BODY
   } stage_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] data_byte;
      logic [7:0] lower_byte;
      logic       is_space;
      logic       is_cr;
      logic       is_lf;
      logic       is_colon;
      logic       is_slash;
      logic       is_ctl;
      logic       is_digit;
   } item_type;

endpackage

>>> design/http_request_header_framer.sv
// HTTP/1.x request framer, one byte per transaction.
// req_ channel: req_mode 0 carries req_data_byte, req_mode 1 restarts the
// request and clears a held error. every request transaction gives exactly
// one rsp_ transaction with status, byte class, the byte and the decoded
// method, version, keep-alive, announced length and body count.
// csr_ channel: csr_index 0 writes max_body_size, 1 writes body_method_mask;
// always ready; the user must write only while no transaction is in flight,
// the block does not enforce this. a request transaction passes the input
// queue then the output register. throughput: one byte per cycle while
// rsp_ready is high, set by the parser update in the back end.
// reset clears the parser to the method stage, drops any queued or pending
// transaction and loads the register defaults (1 MiB, mask 30).
// when rsp_ready is low the response register holds; the two-entry input
// queue keeps taking bytes until full, then req_ready falls.
module http_request_header_framer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_mode,
   input  logic [7:0]                    req_data_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [2:0]                    rsp_byte_class,
   output logic [7:0]                    rsp_echo_byte,
   output logic [2:0]                    rsp_method_code,
   output logic [1:0]                    rsp_version_minor,
   output logic                          rsp_keep_alive,
   output logic [hrhf_pkg::LEN_BITS-1:0] rsp_body_length,
   output logic [hrhf_pkg::LEN_BITS-1:0] rsp_body_received,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [hrhf_pkg::LEN_BITS-1:0] csr_data
);

   logic [hrhf_pkg::LEN_BITS-1:0] max_body_ff;
   logic [6:0]                    mask_ff;

   logic               queue_ready, push, q_valid, q_pop;
   hrhf_pkg::item_type f_item, q_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_body_ff <= hrhf_pkg::MAX_BODY_RESET;
         mask_ff <= hrhf_pkg::BODY_MASK_RESET;
      end else if (csr_valid) begin
         if (csr_index == hrhf_pkg::CSR_MAX_BODY_SIZE) max_body_ff <= csr_data;
         if (csr_index == hrhf_pkg::CSR_BODY_METHOD_MASK) mask_ff <= csr_data[6:0];
      end
   end

   hrhf_front u_front (
      .req_valid     (req_valid),
      .req_mode      (req_mode),
      .req_data_byte (req_data_byte),
      .queue_ready   (queue_ready),
      .req_ready     (req_ready),
      .push          (push),
      .item          (f_item)
   );

   hrhf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (f_item),
      .ready     (queue_ready),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_item  (q_item)
   );

   hrhf_back u_back (
      .clock             (clock),
      .reset             (reset),
      .item_valid        (q_valid),
      .item              (q_item),
      .item_pop          (q_pop),
      .max_body_size     (max_body_ff),
      .body_method_mask  (mask_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_byte_class    (rsp_byte_class),
      .rsp_echo_byte     (rsp_echo_byte),
      .rsp_method_code   (rsp_method_code),
      .rsp_version_minor (rsp_version_minor),
      .rsp_keep_alive    (rsp_keep_alive),
      .rsp_body_length   (rsp_body_length),
      .rsp_body_received (rsp_body_received)
   );

endmodule

>>> design/hrhf_front.sv
module hrhf_front (
   input  logic               req_valid,
   input  logic               req_mode,
   input  logic [7:0]         req_data_byte,
   input  logic               queue_ready,
   output logic               req_ready,
   output logic               push,
   output hrhf_pkg::item_type item
);

   always_comb begin
      item.mode = req_mode;
      item.data_byte = req_data_byte;
      item.lower_byte = (req_data_byte >= 8'h41 && req_data_byte <= 8'h5A) ?
                        (req_data_byte | 8'h20) : req_data_byte;
      item.is_space = (req_data_byte == 8'h20);
      item.is_cr = (req_data_byte == 8'h0D);
      item.is_lf = (req_data_byte == 8'h0A);
      item.is_colon = (req_data_byte == 8'h3A);
      item.is_slash = (req_data_byte == 8'h2F);
      item.is_ctl = (req_data_byte < 8'h20) || (req_data_byte == 8'h7F);
      item.is_digit = (req_data_byte >= 8'h30) && (req_data_byte <= 8'h39);
   end

   assign req_ready = queue_ready;
   assign push = req_valid && queue_ready;

endmodule

>>> design/hrhf_queue.sv
module hrhf_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  hrhf_pkg::item_type push_item,
   output logic               ready,
   input  logic               pop,
   output logic               valid,
   output hrhf_pkg::item_type pop_item
);

   hrhf_pkg::item_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign ready = (count_ff != 2'd2);
   assign valid = (count_ff != 2'd0);
   assign pop_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> design/hrhf_back.sv
module hrhf_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             item_valid,
   input  hrhf_pkg::item_type               item,
   output logic                             item_pop,
   input  logic [hrhf_pkg::LEN_BITS-1:0]    max_body_size,
   input  logic [6:0]                       body_method_mask,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_status,
   output logic [2:0]                       rsp_byte_class,
   output logic [7:0]                       rsp_echo_byte,
   output logic [2:0]                       rsp_method_code,
   output logic [1:0]                       rsp_version_minor,
   output logic                             rsp_keep_alive,
   output logic [hrhf_pkg::LEN_BITS-1:0]    rsp_body_length,
   output logic [hrhf_pkg::LEN_BITS-1:0]    rsp_body_received
);

   localparam int LB = hrhf_pkg::LEN_BITS;

   hrhf_pkg::stage_type stage_ff, stage_in, stage_nx;
   logic          err_hold_ff, err_hold_in;
   logic [1:0]    err_code_ff, err_code_in;
   logic [2:0]    err_class_ff, err_class_in;
   logic [3:0]    tok_ff, tok_in, tok_nx;
   logic [6:0]    mcand_ff, mcand_in, mcand_nx;
   logic [1:0]    vcand_ff, vcand_in, vcand_nx;
   logic [4:0]    klen_ff, klen_in, klen_nx;
   logic [1:0]    kflag_ff, kflag_in, kflag_nx;
   logic [4:0]    vlen_ff, vlen_in, vlen_nx;
   logic [1:0]    vflag_ff, vflag_in, vflag_nx;
   logic [LB-1:0] vnum_ff, vnum_in, vnum_nx;
   logic [2:0]    meth_ff, meth_in, meth_nx;
   logic [1:0]    ver_ff, ver_in, ver_nx;
   logic          ka_ff, ka_in, ka_nx;
   logic [LB-1:0] len_ff, len_in, len_nx;
   logic [LB-1:0] rcv_ff, rcv_in, rcv_nx;
   logic          ustart_ff, ustart_in, ustart_nx;

   logic          out_valid_ff, out_valid_in;
   logic [1:0]    o_status_ff, o_status_in;
   logic [2:0]    o_class_ff, o_class_in;
   logic [7:0]    o_byte_ff, o_byte_in;

   logic          fire, done, clear_all;
   logic [1:0]    status;
   logic [2:0]    cls, stage_cls;
   logic [LB+3:0] prod;
   logic [LB-1:0] rcv_inc;

   assign fire = item_valid && (!out_valid_ff || rsp_ready);
   assign item_pop = fire;

   always_comb begin
      case (stage_ff)
         hrhf_pkg::S_METHOD:  stage_cls = hrhf_pkg::CLS_METHOD;
         hrhf_pkg::S_URI:     stage_cls = hrhf_pkg::CLS_URI;
         hrhf_pkg::S_VERSION: stage_cls = hrhf_pkg::CLS_VERSION;
         hrhf_pkg::S_HKEY:    stage_cls = hrhf_pkg::CLS_KEY;
         hrhf_pkg::S_HVALUE:  stage_cls = hrhf_pkg::CLS_VALUE;
         hrhf_pkg::S_BODY:    stage_cls = hrhf_pkg::CLS_BODY;
         default:             stage_cls = hrhf_pkg::CLS_DELIM;
      endcase
   end

   // next stage
   always_comb begin
      stage_nx = stage_ff;
      case (stage_ff)
         hrhf_pkg::S_METHOD: begin
            if (item.is_space && meth_nx != 3'd0) stage_nx = hrhf_pkg::S_URI;
         end
         hrhf_pkg::S_URI: begin
            if (item.is_space && ustart_ff) stage_nx = hrhf_pkg::S_VERSION;
         end
         hrhf_pkg::S_VERSION: begin
            if (item.is_cr && tok_ff == 4'd8 && vcand_ff != 2'd0) stage_nx = hrhf_pkg::S_LF1;
         end
         hrhf_pkg::S_LF1, hrhf_pkg::S_LF2: begin
            if (item.is_lf) stage_nx = hrhf_pkg::S_HKEY;
         end
         hrhf_pkg::S_HKEY: begin
            if (item.is_cr) begin
               if (klen_ff == 5'd0) stage_nx = hrhf_pkg::S_LF3;
            end else if (item.is_colon) begin
               stage_nx = hrhf_pkg::S_HSPACE;
            end
         end
         hrhf_pkg::S_HSPACE: begin
            if (item.is_space) stage_nx = hrhf_pkg::S_HVALUE;
         end
         hrhf_pkg::S_HVALUE: begin
            if (item.is_cr) stage_nx = hrhf_pkg::S_LF2;
         end
         hrhf_pkg::S_LF3: begin
            if (item.is_lf && len_ff != '0) stage_nx = hrhf_pkg::S_BODY;
         end
         default: stage_nx = stage_ff;
      endcase
   end

   assign prod = ({4'd0, vnum_ff} << 3) + ({4'd0, vnum_ff} << 1)
               + (LB+4)'(item.data_byte[3:0]);
   assign rcv_inc = rcv_ff + LB'(1);

   // datapath and result
   always_comb begin
      status = hrhf_pkg::ST_CONTINUE;
      cls = stage_cls;
      done = 1'b0;
      tok_nx = tok_ff;
      mcand_nx = mcand_ff;
      vcand_nx = vcand_ff;
      klen_nx = klen_ff;
      kflag_nx = kflag_ff;
      vlen_nx = vlen_ff;
      vflag_nx = vflag_ff;
      vnum_nx = vnum_ff;
      meth_nx = meth_ff;
      ver_nx = ver_ff;
      ka_nx = ka_ff;
      len_nx = len_ff;
      rcv_nx = rcv_ff;
      ustart_nx = ustart_ff;
      case (stage_ff)
         hrhf_pkg::S_METHOD: begin
            if (item.is_space) begin
               cls = hrhf_pkg::CLS_DELIM;
               for (int i = 0; i < 7; i++) begin
                  if (mcand_ff[i] && hrhf_pkg::METH_LEN[i] == tok_ff) meth_nx = 3'(i + 1);
               end
               if (meth_nx == 3'd0) status = hrhf_pkg::ST_BAD;
               else tok_nx = 4'd0;
            end else if (tok_ff >= 4'd7) begin
               status = hrhf_pkg::ST_BAD;
            end else begin
               for (int i = 0; i < 7; i++) begin
                  if (tok_ff >= hrhf_pkg::METH_LEN[i] ||
                      hrhf_pkg::METH_NAME[i][tok_ff[2:0]] != item.data_byte)
                     mcand_nx[i] = 1'b0;
               end
               tok_nx = tok_ff + 4'd1;
            end
         end
         hrhf_pkg::S_URI: begin
            if (item.is_space) begin
               cls = hrhf_pkg::CLS_DELIM;
               if (!ustart_ff) status = hrhf_pkg::ST_BAD;
               else tok_nx = 4'd0;
            end else if (item.is_ctl || (!ustart_ff && !item.is_slash)) begin
               status = hrhf_pkg::ST_BAD;
            end else begin
               ustart_nx = 1'b1;
            end
         end
         hrhf_pkg::S_VERSION: begin
            if (item.is_cr) begin
               cls = hrhf_pkg::CLS_DELIM;
               if (tok_ff != 4'd8 || vcand_ff == 2'd0) status = hrhf_pkg::ST_BAD;
               else ver_nx = vcand_ff[1] ? hrhf_pkg::VER_11 : hrhf_pkg::VER_10;
            end else if (tok_ff >= 4'd8) begin
               status = hrhf_pkg::ST_BAD;
            end else begin
               if (tok_ff < 4'd7) begin
                  if (hrhf_pkg::VER_TEXT[tok_ff[2:0]] != item.data_byte) vcand_nx = 2'd0;
               end else begin
                  if (item.data_byte != 8'h30) vcand_nx[0] = 1'b0;
                  if (item.data_byte != 8'h31) vcand_nx[1] = 1'b0;
               end
               tok_nx = tok_ff + 4'd1;
            end
         end
         hrhf_pkg::S_LF1, hrhf_pkg::S_LF2: begin
            if (!item.is_lf) begin
               status = hrhf_pkg::ST_BAD;
            end else begin
               klen_nx = 5'd0;
               kflag_nx = 2'b11;
            end
         end
         hrhf_pkg::S_HKEY: begin
            if (item.is_cr) begin
               cls = hrhf_pkg::CLS_DELIM;
               if (klen_ff != 5'd0) status = hrhf_pkg::ST_BAD;
            end else if (item.is_colon) begin
               cls = hrhf_pkg::CLS_DELIM;
               vlen_nx = 5'd0;
               vflag_nx = 2'b11;
               vnum_nx = '0;
            end else if (item.is_ctl) begin
               status = hrhf_pkg::ST_BAD;
            end else begin
               if (klen_ff >= hrhf_pkg::CLEN_LEN ||
                   hrhf_pkg::KEY_CLEN[klen_ff[3:0]] != item.lower_byte) kflag_nx[0] = 1'b0;
               if (klen_ff >= hrhf_pkg::CONN_LEN ||
                   hrhf_pkg::KEY_CONN[klen_ff[3:0]] != item.lower_byte) kflag_nx[1] = 1'b0;
               if (klen_ff < hrhf_pkg::MATCH_SAT) klen_nx = klen_ff + 5'd1;
            end
         end
         hrhf_pkg::S_HSPACE: begin
            if (!item.is_space) status = hrhf_pkg::ST_BAD;
         end
         hrhf_pkg::S_HVALUE: begin
            if (item.is_cr) begin
               cls = hrhf_pkg::CLS_DELIM;
               if (kflag_ff[0] && klen_ff == hrhf_pkg::CLEN_LEN) len_nx = vnum_ff;
               if (kflag_ff[1] && klen_ff == hrhf_pkg::CONN_LEN)
                  ka_nx = vflag_ff[1] && vlen_ff == hrhf_pkg::KA_LEN;
            end else if (item.is_ctl) begin
               status = hrhf_pkg::ST_BAD;
            end else begin
               if (vflag_ff[0] && item.is_digit) begin
                  vnum_nx = (prod[LB+3:LB] != 4'd0) ? hrhf_pkg::LEN_MAX : prod[LB-1:0];
               end else begin
                  vflag_nx[0] = 1'b0;
               end
               if (vlen_ff >= hrhf_pkg::KA_LEN ||
                   hrhf_pkg::VAL_KA[vlen_ff[3:0]] != item.lower_byte) vflag_nx[1] = 1'b0;
               if (vlen_ff < hrhf_pkg::MATCH_SAT) vlen_nx = vlen_ff + 5'd1;
            end
         end
         hrhf_pkg::S_LF3: begin
            if (!item.is_lf) begin
               status = hrhf_pkg::ST_BAD;
            end else if (len_ff == '0) begin
               status = hrhf_pkg::ST_DONE;
               done = 1'b1;
            end
         end
         default: begin
            if (meth_ff == 3'd0 || !body_method_mask[meth_ff - 3'd1]) begin
               status = hrhf_pkg::ST_BAD;
            end else if (rcv_ff >= max_body_size) begin
               status = hrhf_pkg::ST_TOO_LARGE;
            end else begin
               rcv_nx = rcv_inc;
               if (rcv_inc == len_ff) begin
                  status = hrhf_pkg::ST_DONE;
                  done = 1'b1;
               end
            end
         end
      endcase
   end

   // state update per transaction
   always_comb begin
      stage_in = stage_ff;
      err_hold_in = err_hold_ff;
      err_code_in = err_code_ff;
      err_class_in = err_class_ff;
      tok_in = tok_ff;
      mcand_in = mcand_ff;
      vcand_in = vcand_ff;
      klen_in = klen_ff;
      kflag_in = kflag_ff;
      vlen_in = vlen_ff;
      vflag_in = vflag_ff;
      vnum_in = vnum_ff;
      meth_in = meth_ff;
      ver_in = ver_ff;
      ka_in = ka_ff;
      len_in = len_ff;
      rcv_in = rcv_ff;
      ustart_in = ustart_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      o_status_in = o_status_ff;
      o_class_in = o_class_ff;
      o_byte_in = o_byte_ff;
      clear_all = 1'b0;
      if (fire) begin
         out_valid_in = 1'b1;
         if (item.mode) begin
            err_hold_in = 1'b0;
            err_code_in = hrhf_pkg::ST_CONTINUE;
            ka_in = 1'b0;
            clear_all = 1'b1;
            o_status_in = hrhf_pkg::ST_CONTINUE;
            o_class_in = hrhf_pkg::CLS_DELIM;
            o_byte_in = 8'd0;
         end else if (err_hold_ff) begin
            o_status_in = err_code_ff;
            o_class_in = err_class_ff;
            o_byte_in = item.data_byte;
         end else begin
            o_status_in = status;
            o_class_in = cls;
            o_byte_in = item.data_byte;
            if (status == hrhf_pkg::ST_BAD || status == hrhf_pkg::ST_TOO_LARGE) begin
               err_hold_in = 1'b1;
               err_code_in = status;
               err_class_in = cls;
            end
            stage_in = stage_nx;
            tok_in = tok_nx;
            mcand_in = mcand_nx;
            vcand_in = vcand_nx;
            klen_in = klen_nx;
            kflag_in = kflag_nx;
            vlen_in = vlen_nx;
            vflag_in = vflag_nx;
            vnum_in = vnum_nx;
            meth_in = meth_nx;
            ver_in = ver_nx;
            ka_in = ka_nx;
            len_in = len_nx;
            rcv_in = rcv_nx;
            ustart_in = ustart_nx;
            clear_all = done;
         end
         if (clear_all) begin
            stage_in = hrhf_pkg::S_METHOD;
            tok_in = 4'd0;
            mcand_in = 7'h7F;
            vcand_in = 2'b11;
            klen_in = 5'd0;
            kflag_in = 2'b11;
            vlen_in = 5'd0;
            vflag_in = 2'b11;
            vnum_in = '0;
            meth_in = 3'd0;
            ver_in = hrhf_pkg::VER_UNKNOWN;
            len_in = '0;
            rcv_in = '0;
            ustart_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= hrhf_pkg::S_METHOD;
         err_hold_ff <= 1'b0;
         err_code_ff <= hrhf_pkg::ST_CONTINUE;
         err_class_ff <= hrhf_pkg::CLS_METHOD;
         tok_ff <= 4'd0;
         mcand_ff <= 7'h7F;
         vcand_ff <= 2'b11;
         klen_ff <= 5'd0;
         kflag_ff <= 2'b11;
         vlen_ff <= 5'd0;
         vflag_ff <= 2'b11;
         vnum_ff <= '0;
         meth_ff <= 3'd0;
         ver_ff <= hrhf_pkg::VER_UNKNOWN;
         ka_ff <= 1'b0;
         len_ff <= '0;
         rcv_ff <= '0;
         ustart_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         err_hold_ff <= err_hold_in;
         err_code_ff <= err_code_in;
         err_class_ff <= err_class_in;
         tok_ff <= tok_in;
         mcand_ff <= mcand_in;
         vcand_ff <= vcand_in;
         klen_ff <= klen_in;
         kflag_ff <= kflag_in;
         vlen_ff <= vlen_in;
         vflag_ff <= vflag_in;
         vnum_ff <= vnum_in;
         meth_ff <= meth_in;
         ver_ff <= ver_in;
         ka_ff <= ka_in;
         len_ff <= len_in;
         rcv_ff <= rcv_in;
         ustart_ff <= ustart_in;
         out_valid_ff <= out_valid_in;
      end
   end

   logic [2:0]    o_meth_ff;
   logic [1:0]    o_ver_ff;
   logic          o_ka_ff;
   logic [LB-1:0] o_len_ff;
   logic [LB-1:0] o_rcv_ff;

   // result payload shows values before the end-of-request clear
   always_ff @(posedge clock) begin
      o_status_ff <= o_status_in;
      o_class_ff <= o_class_in;
      o_byte_ff <= o_byte_in;
      if (fire) begin
         if (item.mode) begin
            o_meth_ff <= 3'd0;
            o_ver_ff <= hrhf_pkg::VER_UNKNOWN;
            o_ka_ff <= 1'b0;
            o_len_ff <= '0;
            o_rcv_ff <= '0;
         end else if (err_hold_ff) begin
            o_meth_ff <= meth_ff;
            o_ver_ff <= ver_ff;
            o_ka_ff <= ka_ff;
            o_len_ff <= len_ff;
            o_rcv_ff <= rcv_ff;
         end else begin
            o_meth_ff <= meth_nx;
            o_ver_ff <= ver_nx;
            o_ka_ff <= ka_nx;
            o_len_ff <= len_nx;
            o_rcv_ff <= rcv_nx;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_status = o_status_ff;
   assign rsp_byte_class = o_class_ff;
   assign rsp_echo_byte = o_byte_ff;
   assign rsp_method_code = o_meth_ff;
   assign rsp_version_minor = o_ver_ff;
   assign rsp_keep_alive = o_ka_ff;
   assign rsp_body_length = o_len_ff;
   assign rsp_body_received = o_rcv_ff;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam int LEN_BITS = hrhf_pkg::LEN_BITS;
   localparam int WATCHDOG_LIMIT = 4000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_mode = 1'b0;
   logic [7:0] req_data_byte = 8'd0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic [2:0] rsp_byte_class;
   logic [7:0] rsp_echo_byte;
   logic [2:0] rsp_method_code;
   logic [1:0] rsp_version_minor;
   logic rsp_keep_alive;
   logic [LEN_BITS-1:0] rsp_body_length;
   logic [LEN_BITS-1:0] rsp_body_received;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = 1'b0;
   logic [LEN_BITS-1:0] csr_data = '0;

   http_request_header_framer dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   typedef struct packed {
      logic [1:0] status;
      logic [2:0] byte_class;
      logic [7:0] echo_byte;
      logic [2:0] method_code;
      logic [1:0] version_minor;
      logic keep_alive;
      logic [LEN_BITS-1:0] body_length;
      logic [LEN_BITS-1:0] body_received;
   } frame_result_type;

   typedef struct {
      logic mode;
      logic [7:0] data;
      logic fixed;
      logic [1:0] status;
      logic [2:0] byte_class;
   } stim_row_type;

   frame_result_type pending_results[$];
   int unsigned fail_count = 0;
   int unsigned idle_cycles = 0;
   int unsigned sent_count = 0;
   bit quiet_tail = 0;

   // shadow of the parser
   logic [LEN_BITS-1:0] shadow_max_body;
   logic [6:0] shadow_body_mask;
   hrhf_pkg::stage_type p_stage;
   bit p_err;
   logic [1:0] p_err_code;
   logic [2:0] p_err_class;
   int p_tok, p_klen, p_vlen;
   logic [6:0] p_meth_cand;
   logic [1:0] p_ver_cand, p_key_flags, p_val_flags;
   logic [LEN_BITS-1:0] p_vnum, p_len, p_rcvd;
   logic [2:0] p_meth;
   logic [1:0] p_ver;
   logic p_ka;
   bit p_uri;

   string meth_text[7] = '{"GET", "PUT", "POST", "PATCH", "DELETE", "OPTIONS", "HEAD"};
   string clen_text = "content-length";
   string conn_text = "connection";
   string ka_text = "keep-alive";
   string ver_prefix = "HTTP/1.";

   function automatic bit ctl_byte(logic [7:0] b);
      return b < 8'h20 || b == 8'h7f;
   endfunction

   function automatic logic [7:0] fold_case(logic [7:0] b);
      return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
   endfunction

   function automatic void clear_request();
      p_stage = hrhf_pkg::S_METHOD; p_tok = 0; p_meth_cand = 7'h7f; p_ver_cand = 2'b11;
      p_klen = 0; p_key_flags = 2'b11; p_vlen = 0; p_val_flags = 2'b11; p_vnum = '0;
      p_meth = '0; p_ver = '0; p_len = '0; p_rcvd = '0; p_uri = 0;
   endfunction

   function automatic frame_result_type predict_frame(logic mode, logic [7:0] b);
      frame_result_type r;
      logic [1:0] st;
      logic [2:0] cls;
      bit done;
      logic [LEN_BITS-1:0] d;
      st = hrhf_pkg::ST_CONTINUE;
      done = 0;
      if (mode) begin
         p_err = 0; p_err_code = '0; p_ka = 0;
         clear_request();
         r = '{hrhf_pkg::ST_CONTINUE, hrhf_pkg::CLS_DELIM, 8'd0, p_meth, p_ver, p_ka,
               p_len, p_rcvd};
         return r;
      end
      if (p_err) begin
         r = '{p_err_code, p_err_class, b, p_meth, p_ver, p_ka, p_len, p_rcvd};
         return r;
      end
      case (p_stage)
         hrhf_pkg::S_METHOD: cls = hrhf_pkg::CLS_METHOD;
         hrhf_pkg::S_URI: cls = hrhf_pkg::CLS_URI;
         hrhf_pkg::S_VERSION: cls = hrhf_pkg::CLS_VERSION;
         hrhf_pkg::S_HKEY: cls = hrhf_pkg::CLS_KEY;
         hrhf_pkg::S_HVALUE: cls = hrhf_pkg::CLS_VALUE;
         hrhf_pkg::S_BODY: cls = hrhf_pkg::CLS_BODY;
         default: cls = hrhf_pkg::CLS_DELIM;
      endcase
      case (p_stage)
         hrhf_pkg::S_METHOD: begin
            if (b == " ") begin
               cls = hrhf_pkg::CLS_DELIM;
               for (int i = 0; i < 7; i++)
                  if (p_meth_cand[i] && meth_text[i].len() == p_tok) p_meth = 3'(i + 1);
               if (p_meth == 0) st = hrhf_pkg::ST_BAD;
               else begin
                  p_stage = hrhf_pkg::S_URI; p_tok = 0;
               end
            end else if (p_tok >= 7) st = hrhf_pkg::ST_BAD;
            else begin
               for (int i = 0; i < 7; i++)
                  if (p_tok >= meth_text[i].len() || meth_text[i][p_tok] != b)
                     p_meth_cand[i] = 1'b0;
               p_tok++;
            end
         end
         hrhf_pkg::S_URI: begin
            if (b == " ") begin
               cls = hrhf_pkg::CLS_DELIM;
               if (!p_uri) st = hrhf_pkg::ST_BAD;
               else begin
                  p_stage = hrhf_pkg::S_VERSION; p_tok = 0;
               end
            end else if (ctl_byte(b) || (!p_uri && b != "/")) st = hrhf_pkg::ST_BAD;
            else p_uri = 1;
         end
         hrhf_pkg::S_VERSION: begin
            if (b == 8'h0d) begin
               cls = hrhf_pkg::CLS_DELIM;
               if (p_tok != 8 || p_ver_cand == 0) st = hrhf_pkg::ST_BAD;
               else begin
                  p_ver = p_ver_cand[1] ? hrhf_pkg::VER_11 : hrhf_pkg::VER_10;
                  p_stage = hrhf_pkg::S_LF1;
               end
            end else if (p_tok >= 8) st = hrhf_pkg::ST_BAD;
            else begin
               if (p_tok < 7) begin
                  if (ver_prefix[p_tok] != b) p_ver_cand = 2'b00;
               end else begin
                  if (b != "0") p_ver_cand[0] = 1'b0;
                  if (b != "1") p_ver_cand[1] = 1'b0;
               end
               p_tok++;
            end
         end
         hrhf_pkg::S_LF1, hrhf_pkg::S_LF2: begin
            if (b != 8'h0a) st = hrhf_pkg::ST_BAD;
            else begin
               p_stage = hrhf_pkg::S_HKEY; p_klen = 0; p_key_flags = 2'b11;
            end
         end
         hrhf_pkg::S_HKEY: begin
            if (b == 8'h0d) begin
               cls = hrhf_pkg::CLS_DELIM;
               if (p_klen > 0) st = hrhf_pkg::ST_BAD; else p_stage = hrhf_pkg::S_LF3;
            end else if (b == ":") begin
               cls = hrhf_pkg::CLS_DELIM; p_stage = hrhf_pkg::S_HSPACE;
               p_vlen = 0; p_val_flags = 2'b11; p_vnum = '0;
            end else if (ctl_byte(b)) st = hrhf_pkg::ST_BAD;
            else begin
               if (p_klen >= 14 || clen_text[p_klen] != fold_case(b)) p_key_flags[0] = 1'b0;
               if (p_klen >= 10 || conn_text[p_klen] != fold_case(b)) p_key_flags[1] = 1'b0;
               if (p_klen < 31) p_klen++;
            end
         end
         hrhf_pkg::S_HSPACE: begin
            if (b != " ") st = hrhf_pkg::ST_BAD; else p_stage = hrhf_pkg::S_HVALUE;
         end
         hrhf_pkg::S_HVALUE: begin
            if (b == 8'h0d) begin
               cls = hrhf_pkg::CLS_DELIM;
               if (p_key_flags[0] && p_klen == 14) p_len = p_vnum;
               if (p_key_flags[1] && p_klen == 10) p_ka = p_val_flags[1] && p_vlen == 10;
               p_stage = hrhf_pkg::S_LF2;
            end else if (ctl_byte(b)) st = hrhf_pkg::ST_BAD;
            else begin
               if (p_val_flags[0] && b >= "0" && b <= "9") begin
                  d = LEN_BITS'(b - "0");
                  if (p_vnum > (hrhf_pkg::LEN_MAX - d) / 10) p_vnum = hrhf_pkg::LEN_MAX;
                  else p_vnum = p_vnum * 10 + d;
               end else p_val_flags[0] = 1'b0;
               if (p_vlen >= 10 || ka_text[p_vlen] != fold_case(b)) p_val_flags[1] = 1'b0;
               if (p_vlen < 31) p_vlen++;
            end
         end
         hrhf_pkg::S_LF3: begin
            if (b != 8'h0a) st = hrhf_pkg::ST_BAD;
            else if (p_len == 0) begin
               st = hrhf_pkg::ST_DONE; done = 1;
            end else p_stage = hrhf_pkg::S_BODY;
         end
         default: begin
            if (p_meth == 0 || !shadow_body_mask[p_meth - 1]) st = hrhf_pkg::ST_BAD;
            else if (p_rcvd >= shadow_max_body) st = hrhf_pkg::ST_TOO_LARGE;
            else begin
               p_rcvd = p_rcvd + 1;
               if (p_rcvd == p_len) begin
                  st = hrhf_pkg::ST_DONE; done = 1;
               end
            end
         end
      endcase
      if (st == hrhf_pkg::ST_BAD || st == hrhf_pkg::ST_TOO_LARGE) begin
         p_err = 1; p_err_code = st; p_err_class = cls;
      end
      r = '{st, cls, b, p_meth, p_ver, p_ka, p_len, p_rcvd};
      if (done) clear_request();
      return r;
   endfunction

   // request side
   task automatic send_frame(logic mode, logic [7:0] b);
      int gap;
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 12);
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_mode = mode;
      req_data_byte = b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(predict_frame(mode, b));
      sent_count++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_frame(1'b0, s[i]);
   endtask

   task automatic drain_results();
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [LEN_BITS-1:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == hrhf_pkg::CSR_MAX_BODY_SIZE) shadow_max_body = value;
      else shadow_body_mask = value[6:0];
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic string random_token(int n, bit allow_ctl);
      string s = "";
      byte c;
      for (int i = 0; i < n; i++) begin
         c = allow_ctl && $urandom_range(0, 20) == 0 ? byte'($urandom_range(0, 255))
                                                     : byte'($urandom_range(8'h21, 8'h7e));
         if (c == ":" || c == " ") c = "x";
         s = {s, string'(c)};
      end
      return s;
   endfunction

   function automatic string mixed_case(string s);
      for (int i = 0; i < s.len(); i++)
         if ($urandom_range(0, 1) && s[i] >= "a" && s[i] <= "z") s[i] = s[i] - 8'd32;
      return s;
   endfunction

   // one well-formed request with random content, sometimes broken
   task automatic send_request();
      int m, blen;
      string r;
      m = $urandom_range(0, 6);
      blen = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      r = {meth_text[m], " /", random_token($urandom_range(0, 6), 0), " HTTP/1.",
           $urandom_range(0, 1) ? "1" : "0", "\r\n"};
      if ($urandom_range(0, 1))
         r = {r, mixed_case("connection"), ": ",
              $urandom_range(0, 1) ? mixed_case("keep-alive") : "close", "\r\n"};
      if ($urandom_range(0, 1))
         r = {r, random_token($urandom_range(0, 20), 0), ": ",
              random_token($urandom_range(0, 20), 0), "\r\n"};
      if (blen != 0)
         r = {r, mixed_case("content-length"), ": ", $sformatf("%0d", blen), "\r\n"};
      r = {r, "\r\n", random_token(blen, 1)};
      if ($urandom_range(0, 7) == 0)
         r[$urandom_range(0, r.len() - 1)] = byte'($urandom_range(0, 255));
      send_text(r);
      if (p_err || $urandom_range(0, 9) == 0) send_frame(1'b1, 8'($urandom_range(0, 255)));
   endtask

   stim_row_type directed_rows[$];

   task automatic add_row(logic mode, logic [7:0] b, logic fixed,
                          logic [1:0] st, logic [2:0] cls);
      directed_rows.push_back('{mode, b, fixed, st, cls});
   endtask

   // response side and checks
   always @(posedge clock) begin
      frame_result_type want, got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_status, rsp_byte_class, rsp_echo_byte, rsp_method_code,
                 rsp_version_minor, rsp_keep_alive, rsp_body_length, rsp_body_received};
         if (pending_results.size() == 0) begin
            $error("response transaction with nothing expected");
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
               $error("status exp %0d got %0d", want.status, got.status); fail_count++;
            end
            if (got.byte_class !== want.byte_class) begin
               $error("byte_class exp %0d got %0d", want.byte_class, got.byte_class);
               fail_count++;
            end
            if (got.echo_byte !== want.echo_byte) begin
               $error("echo_byte exp %0h got %0h", want.echo_byte, got.echo_byte);
               fail_count++;
            end
            if (got.method_code !== want.method_code) begin
               $error("method_code exp %0d got %0d", want.method_code, got.method_code);
               fail_count++;
            end
            if (got.version_minor !== want.version_minor) begin
               $error("version_minor exp %0d got %0d", want.version_minor,
                      got.version_minor);
               fail_count++;
            end
            if (got.keep_alive !== want.keep_alive) begin
               $error("keep_alive exp %0d got %0d", want.keep_alive, got.keep_alive);
               fail_count++;
            end
            if (got.body_length !== want.body_length) begin
               $error("body_length exp %0d got %0d", want.body_length, got.body_length);
               fail_count++;
            end
            if (got.body_received !== want.body_received) begin
               $error("body_received exp %0d got %0d", want.body_received,
                      got.body_received);
               fail_count++;
            end
         end
      end
   end

   always @(negedge clock) begin
      int burst;
      if (reset || quiet_tail) rsp_ready <= 1'b1;
      else if ($urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         burst = $urandom_range(1, 12);
         repeat (burst) @(negedge clock);
         rsp_ready <= 1'b1;
      end else rsp_ready <= 1'b1;
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("** http_request_header_framer: FAILED **");
         $finish;
      end
   end

   initial begin
      int unsigned sent;
      frame_result_type want;
      shadow_max_body = hrhf_pkg::MAX_BODY_RESET;
      shadow_body_mask = hrhf_pkg::BODY_MASK_RESET;
      p_err = 0; p_err_code = '0; p_err_class = '0; p_ka = 0;
      clear_request();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: restart, bad method, held error, long method, uri without leading slash
      add_row(1'b1, 8'hff, 1'b1, hrhf_pkg::ST_CONTINUE, hrhf_pkg::CLS_DELIM);
      add_row(1'b0, " ", 1'b1, hrhf_pkg::ST_BAD, hrhf_pkg::CLS_DELIM);
      add_row(1'b0, 8'h00, 1'b1, hrhf_pkg::ST_BAD, hrhf_pkg::CLS_DELIM);
      add_row(1'b1, 8'h00, 1'b1, hrhf_pkg::ST_CONTINUE, hrhf_pkg::CLS_DELIM);
      for (int i = 0; i < 7; i++)
         add_row(1'b0, "A", 1'b1, hrhf_pkg::ST_CONTINUE, hrhf_pkg::CLS_METHOD);
      add_row(1'b0, "A", 1'b1, hrhf_pkg::ST_BAD, hrhf_pkg::CLS_METHOD);
      add_row(1'b1, 8'h55, 1'b1, hrhf_pkg::ST_CONTINUE, hrhf_pkg::CLS_DELIM);
      add_row(1'b0, "P", 1'b0, hrhf_pkg::ST_CONTINUE, hrhf_pkg::CLS_METHOD);
      add_row(1'b0, "U", 1'b0, hrhf_pkg::ST_CONTINUE, hrhf_pkg::CLS_METHOD);
      add_row(1'b0, "T", 1'b0, hrhf_pkg::ST_CONTINUE, hrhf_pkg::CLS_METHOD);
      add_row(1'b0, " ", 1'b1, hrhf_pkg::ST_CONTINUE, hrhf_pkg::CLS_DELIM);
      add_row(1'b0, "x", 1'b1, hrhf_pkg::ST_BAD, hrhf_pkg::CLS_URI);
      add_row(1'b1, 8'h00, 1'b1, hrhf_pkg::ST_CONTINUE, hrhf_pkg::CLS_DELIM);
      foreach (directed_rows[i]) begin
         send_frame(directed_rows[i].mode, directed_rows[i].data);
         if (directed_rows[i].fixed) begin
            want = pending_results[$];
            if (want.status !== directed_rows[i].status ||
                want.byte_class !== directed_rows[i].byte_class) begin
               $error("directed row %0d: status exp %0d, class exp %0d", i,
                      directed_rows[i].status, directed_rows[i].byte_class);
               fail_count++;
            end
         end
      end
      // every method, version, saturating length, too large, keep-alive
      for (int m = 0; m < 7; m++) begin
         send_text({meth_text[m], " / HTTP/1.", m[0] ? "0" : "1", "\r\n",
                    "Content-Length: 2\r\n\r\nab"});
         send_frame(1'b1, 8'h00);
      end
      send_text("GET /a HTTP/1.10\r\n");
      send_frame(1'b1, 8'h00);
      send_text({"POST / HTTP/1.1\r\nCONNECTION: Keep-Alive\r\n",
                 "content-length: 99999999999999999999\r\n\r\n"});
      drain_results();
      write_csr(hrhf_pkg::CSR_MAX_BODY_SIZE, '0);
      write_csr(hrhf_pkg::CSR_BODY_METHOD_MASK, LEN_BITS'(7'h7f));
      send_text("x");
      send_frame(1'b1, 8'h00);
      send_text("GET / HTTP/1.1\r\n:\r\n\r\n");
      drain_results();
      write_csr(hrhf_pkg::CSR_MAX_BODY_SIZE, hrhf_pkg::LEN_MAX);
      write_csr(hrhf_pkg::CSR_BODY_METHOD_MASK, LEN_BITS'(7'h00));
      send_text("PUT / HTTP/1.0\r\ncontent-length: 1\r\n\r\nz");
      send_frame(1'b1, 8'h00);

      // random phases with different register settings
      sent = sent_count;
      for (int phase = 0; phase < 6; phase++) begin
         drain_results();
         write_csr(hrhf_pkg::CSR_MAX_BODY_SIZE, phase == 0 ? LEN_BITS'(1048576) :
                   LEN_BITS'($urandom_range(0, 14)));
         write_csr(hrhf_pkg::CSR_BODY_METHOD_MASK,
                   phase == 1 ? LEN_BITS'(7'h7f) : LEN_BITS'($urandom_range(0, 127)));
         if (phase == 5) quiet_tail = 1;
         while (sent_count < sent + (phase + 1) * 200) begin
            if ($urandom_range(0, 9) == 0)
               send_frame(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            else send_request();
         end
      end

      drain_results();
      if (fail_count == 0) $display("** http_request_header_framer: PASSED **");
      else $display("** http_request_header_framer: FAILED **");
      $finish;
   end

endmodule
